### rtl/sfb_pkg.sv
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types, constants and CRC helpers for the sensor frame builder.
// ----------------------------------------------------------------------------
package sfb_pkg;

    localparam int unsigned FRAME_LEN   = 14;
    localparam int unsigned CRC_SPAN    = 11;
    localparam int unsigned IDX_W       = 4;

    localparam logic [IDX_W-1:0] IDX_FIRST  = 4'd0;
    localparam logic [IDX_W-1:0] IDX_CRC_LO = 4'd11;
    localparam logic [IDX_W-1:0] IDX_CRC_HI = 4'd12;
    localparam logic [IDX_W-1:0] IDX_LAST   = 4'd13;
    localparam logic [IDX_W-1:0] IDX_HDR_TOP = 4'd10;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  FRAME_END = 8'h0D;

    localparam logic [15:0] NODE_ID_RESET    = 16'd1807;
    localparam logic [7:0]  FRAME_TYPE_RESET = 8'd8;

    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [0:0] {
        REG_NODE_ID    = 1'b0,
        REG_FRAME_TYPE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic signed [15:0] humidity;
        logic signed [15:0] temperature;
        logic [15:0]        light_level;
        logic               rain_bit;
        logic               error_flag;
    } sfb_in_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } sfb_out_t;

    typedef struct packed {
        logic [15:0]        node_id;
        logic [7:0]         frame_type;
        logic signed [15:0] humidity;
        logic signed [15:0] temperature;
        logic [15:0]        light_level;
        logic               rain_bit;
        logic               error_flag;
    } sfb_rec_t;

    typedef enum logic [0:0] {
        BACK_IDLE = 1'b0,
        BACK_SEND = 1'b1
    } back_state_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] acc;
        acc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (acc[0])
                acc = (acc >> 1) ^ CRC_POLY;
            else
                acc = acc >> 1;
        end
        return acc;
    endfunction

    function automatic logic [7:0] header_byte(input sfb_rec_t rec,
                                               input logic [IDX_W-1:0] idx);
        logic [87:0]      hdr;
        logic [IDX_W-1:0] sel;
        logic [87:0]      shifted;
        hdr = {rec.node_id, rec.frame_type, rec.humidity, rec.temperature,
               rec.light_level, 7'b0, rec.rain_bit, 7'b0, rec.error_flag};
        sel = IDX_HDR_TOP - idx;
        shifted = hdr >> {sel, 3'b000};
        return shifted[7:0];
    endfunction

endpackage

### rtl/sensor_frame_builder_crc16.sv
// ----------------------------------------------------------------------------
// sensor_frame_builder_crc16
// Turns each reading set into a 14-byte frame with CRC-16/Modbus.
//
//   channel | direction | payload    | handshake
//   in      | input     | sfb_in_t   | in_valid / in_ready
//   out     | output    | sfb_out_t  | out_valid / out_ready
//   cfg     | input     | 16-bit reg | cfg_we, no wait
//
// One frame byte per cycle while the output is not stalled; a reading set
// holds the serializer until its last byte goes out, and only then loads another.
// A set passes the front register, queue and record register before output.
// Reset clears the queue and the serializer; registers return to defaults.
// An output stall holds the serializer; the front and queue keep taking
// sets until the queue fills.
// ----------------------------------------------------------------------------
module sensor_frame_builder_crc16
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  sfb_pkg::sfb_in_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output sfb_pkg::sfb_out_t                 out_data,
    input  logic                              cfg_we,
    input  sfb_pkg::cfg_index_t               cfg_index,
    input  logic [sfb_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sfb_pkg::*;

    logic     push_valid;
    logic     push_ready;
    sfb_rec_t push_data;
    logic     pop_valid;
    logic     pop_ready;
    sfb_rec_t pop_data;

    sfb_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    sfb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    sfb_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

### rtl/sfb_front.sv
// ----------------------------------------------------------------------------
// sfb_front
// Holds the configuration registers, accepts reading sets and tags each
// with the current node id and frame type before queuing it.
// ----------------------------------------------------------------------------
module sfb_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  sfb_pkg::sfb_in_t                  in_data,
    input  logic                              cfg_we,
    input  sfb_pkg::cfg_index_t               cfg_index,
    input  logic [sfb_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              push_valid,
    input  logic                              push_ready,
    output sfb_pkg::sfb_rec_t                 push_data
);
    import sfb_pkg::*;

    logic [15:0] node_id_reg;
    logic [7:0]  frame_type_reg;
    logic        fr_valid_reg;
    logic        fr_valid_next;
    sfb_rec_t    fr_rec_reg;
    logic        take;

    assign in_ready   = !fr_valid_reg || push_ready;
    assign take       = in_valid && in_ready;
    assign push_valid = fr_valid_reg;
    assign push_data  = fr_rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg    <= NODE_ID_RESET;
            frame_type_reg <= FRAME_TYPE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NODE_ID:    node_id_reg    <= cfg_data[15:0];
                REG_FRAME_TYPE: frame_type_reg <= cfg_data[7:0];
                default:        node_id_reg    <= node_id_reg;
            endcase
        end
    end

    always_comb
    begin
        priority if (take)
            fr_valid_next = 1'b1;
        else if (push_ready)
            fr_valid_next = 1'b0;
        else
            fr_valid_next = fr_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fr_valid_reg <= 1'b0;
        else
            fr_valid_reg <= fr_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            fr_rec_reg.node_id     <= node_id_reg;
            fr_rec_reg.frame_type  <= frame_type_reg;
            fr_rec_reg.humidity    <= in_data.humidity;
            fr_rec_reg.temperature <= in_data.temperature;
            fr_rec_reg.light_level <= in_data.light_level;
            fr_rec_reg.rain_bit    <= in_data.rain_bit;
            fr_rec_reg.error_flag  <= in_data.error_flag;
        end
    end

endmodule

### rtl/sfb_queue.sv
// ----------------------------------------------------------------------------
// sfb_queue
// Short first-in first-out queue of tagged reading sets between the front
// and the frame serializer.
// ----------------------------------------------------------------------------
module sfb_queue
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  sfb_pkg::sfb_rec_t  push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output sfb_pkg::sfb_rec_t  pop_data
);
    import sfb_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sfb_rec_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/sfb_back.sv
// ----------------------------------------------------------------------------
// sfb_back
// Frame serializer: walks the fourteen frame bytes of one reading set,
// folds the CRC-16/Modbus in a byte at a time and drives the output register.
// ----------------------------------------------------------------------------
module sfb_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  sfb_pkg::sfb_rec_t  pop_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sfb_pkg::sfb_out_t  out_data
);
    import sfb_pkg::*;

    back_state_t      state_reg;
    back_state_t      state_next;
    sfb_rec_t         rec_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [15:0]      crc_reg;
    logic             out_valid_reg;
    sfb_out_t         out_data_reg;

    logic             advance;
    logic             is_last;
    logic             load;
    logic             in_header;
    logic [7:0]       cur_byte;

    assign is_last   = (idx_reg == IDX_LAST);
    assign in_header = (idx_reg < IDX_CRC_LO);
    assign load      = pop_valid && pop_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (pop_valid)
                    state_next = BACK_SEND;
            end
            BACK_SEND:
            begin
                if (advance && is_last && !pop_valid)
                    state_next = BACK_IDLE;
            end
            default: state_next = BACK_IDLE;
        endcase
    end

    always_comb
    begin
        advance   = 1'b0;
        pop_ready = 1'b0;
        unique case (state_reg)
            BACK_IDLE:
            begin
                pop_ready = 1'b1;
            end
            BACK_SEND:
            begin
                advance   = !out_valid_reg || out_ready;
                pop_ready = advance && is_last;
            end
            default:
            begin
                pop_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        priority if (in_header)
            cur_byte = header_byte(rec_reg, idx_reg);
        else if (idx_reg == IDX_CRC_LO)
            cur_byte = crc_reg[7:0];
        else if (idx_reg == IDX_CRC_HI)
            cur_byte = crc_reg[15:8];
        else
            cur_byte = FRAME_END;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= IDX_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (load)
                idx_reg <= IDX_FIRST;
            else if (advance)
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= pop_data;
            crc_reg <= CRC_INIT;
        end
        else if (advance && in_header)
        begin
            crc_reg <= crc_byte(crc_reg, cur_byte);
        end
        if (advance)
        begin
            out_data_reg.frame_byte <= cur_byte;
            out_data_reg.last_byte  <= is_last;
        end
    end

endmodule

### rtl/sfb_checker.sv
// ----------------------------------------------------------------------------
// sfb_checker
// Port-level checks for the sensor frame builder, bound to the top level.
// ----------------------------------------------------------------------------
module sfb_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  sfb_pkg::sfb_out_t  out_data
);
    import sfb_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transaction changed while stalled");

    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last_byte |-> out_data.frame_byte == FRAME_END)
        else $error("last byte of frame is not the end marker");

    a_no_short: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last_byte |=>
            !(out_valid && out_data.last_byte))
        else $error("two frame ends in consecutive transactions");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> in_ready && !out_valid)
        else $error("block not empty right after reset");

endmodule

bind sensor_frame_builder_crc16 sfb_checker u_sfb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
